/* hdl/bet_pkg.sv */
// Shared types, constants and codes of the byte escape translator.
`timescale 1ns / 1ps
`default_nettype none

package bet_pkg;

    // Sizes of the substitution stores.
    localparam int NEEDLE_SLOTS    = 16;
    localparam int MAX_REPLACEMENT = 16;
    localparam int PREFIX_SLOT     = 16;
    localparam int SUFFIX_SLOT     = 17;
    localparam int SLOT_COUNT      = 18;
    localparam int MAP_DEPTH       = 256;
    localparam int REP_DEPTH       = SLOT_COUNT * MAX_REPLACEMENT;

    // Field and index widths.
    localparam int OP_W       = 3;
    localparam int BYTE_W     = 8;
    localparam int SLOT_W     = 5;
    localparam int POS_W      = 4;
    localparam int LEN_W      = 5;
    localparam int TOTAL_W    = 32;
    localparam int NEEDLE_W   = $clog2(NEEDLE_SLOTS);
    localparam int IDX_W      = $clog2(MAX_REPLACEMENT);
    localparam int MAP_W      = NEEDLE_W + 1;
    localparam int MAP_ADDR_W = $clog2(MAP_DEPTH);
    localparam int REP_ADDR_W = $clog2(REP_DEPTH);

    // Operation codes of an input word.
    localparam logic [OP_W-1:0] OP_SET_MAP    = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE_SLOT = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_LEN    = 3'd2;
    localparam logic [OP_W-1:0] OP_DATA       = 3'd3;
    localparam logic [OP_W-1:0] OP_END        = 3'd4;

    // Source of an emitted word.
    localparam logic [1:0] KIND_RAM  = 2'd0;
    localparam logic [1:0] KIND_LIT  = 2'd1;
    localparam logic [1:0] KIND_TERM = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [BYTE_W-1:0] byte_value;
        logic              map_enable;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  position;
        logic [LEN_W-1:0]  length;
    } in_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               terminator;
        logic [TOTAL_W-1:0] total_length;
        logic               last;
    } out_word_t;

    // Controller to datapath.
    typedef struct packed {
        logic              load_item;
        logic              do_cfg;
        logic              set_prefix;
        logic              issue;
        logic [1:0]        kind;
        logic [SLOT_W-1:0] slot;
        logic [IDX_W-1:0]  idx;
        logic              last;
    } bet_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic                prefix_sent;
        logic                is_needle;
        logic [NEEDLE_W-1:0] needle_slot;
        logic [LEN_W-1:0]    prefix_len;
        logic [LEN_W-1:0]    needle_len;
        logic [LEN_W-1:0]    suffix_len;
        logic                can_issue;
    } bet_status_t;

endpackage

`default_nettype wire

/* hdl/bet_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hdl/bet_ctrl.sv */
// Controller state machine: sequences prefix, body or passed byte, suffix and terminator words.
`timescale 1ns / 1ps
`default_nettype none

module bet_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire bet_pkg::bet_status_t sts,
    output bet_pkg::bet_cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_PREFIX = 3'd2;
    localparam logic [2:0] ST_BODY   = 3'd3;
    localparam logic [2:0] ST_PASS   = 3'd4;
    localparam logic [2:0] ST_SUFFIX = 3'd5;
    localparam logic [2:0] ST_TERM   = 3'd6;

    logic [2:0]                    state_reg, state_next;
    logic [bet_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic [bet_pkg::LEN_W-1:0]     cur_len;
    logic                          idx_end;
    logic                          is_data;
    logic [2:0]                    after_prefix;

    assign s_ready = (state_reg == ST_IDLE);
    assign is_data = (sts.op == bet_pkg::OP_DATA);

    always_comb begin
        case (state_reg)
            ST_PREFIX: cur_len = sts.prefix_len;
            ST_BODY:   cur_len = sts.needle_len;
            ST_SUFFIX: cur_len = sts.suffix_len;
            default:   cur_len = '0;
        endcase
    end

    assign idx_end = ((bet_pkg::LEN_W'(idx_reg) + bet_pkg::LEN_W'(1)) == cur_len);

    // Where the sequence goes once the prefix is done or skipped.
    always_comb begin
        if (is_data) begin
            if (!sts.is_needle) begin
                after_prefix = ST_PASS;
            end else if (sts.needle_len != '0) begin
                after_prefix = ST_BODY;
            end else begin
                after_prefix = ST_IDLE;
            end
        end else if (sts.suffix_len != '0) begin
            after_prefix = ST_SUFFIX;
        end else begin
            after_prefix = ST_TERM;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                idx_next = '0;
                if (is_data || sts.op == bet_pkg::OP_END) begin
                    cmd.set_prefix = 1'b1;
                    if (!sts.prefix_sent && sts.prefix_len != '0) begin
                        state_next = ST_PREFIX;
                    end else begin
                        state_next = after_prefix;
                    end
                end else begin
                    cmd.do_cfg = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_PREFIX: begin
                cmd.kind = bet_pkg::KIND_RAM;
                cmd.slot = bet_pkg::SLOT_W'(bet_pkg::PREFIX_SLOT);
                cmd.idx  = idx_reg;
                cmd.last = idx_end && (after_prefix == ST_IDLE);
                if (sts.can_issue) begin
                    cmd.issue = 1'b1;
                    idx_next  = idx_reg + bet_pkg::IDX_W'(1);
                    if (idx_end) begin
                        idx_next   = '0;
                        state_next = after_prefix;
                    end
                end
            end
            ST_BODY: begin
                cmd.kind = bet_pkg::KIND_RAM;
                cmd.slot = bet_pkg::SLOT_W'(sts.needle_slot);
                cmd.idx  = idx_reg;
                cmd.last = idx_end;
                if (sts.can_issue) begin
                    cmd.issue = 1'b1;
                    idx_next  = idx_reg + bet_pkg::IDX_W'(1);
                    if (idx_end) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PASS: begin
                cmd.kind = bet_pkg::KIND_LIT;
                cmd.last = 1'b1;
                if (sts.can_issue) begin
                    cmd.issue  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SUFFIX: begin
                cmd.kind = bet_pkg::KIND_RAM;
                cmd.slot = bet_pkg::SLOT_W'(bet_pkg::SUFFIX_SLOT);
                cmd.idx  = idx_reg;
                if (sts.can_issue) begin
                    cmd.issue = 1'b1;
                    idx_next  = idx_reg + bet_pkg::IDX_W'(1);
                    if (idx_end) begin
                        idx_next   = '0;
                        state_next = ST_TERM;
                    end
                end
            end
            ST_TERM: begin
                cmd.kind = bet_pkg::KIND_TERM;
                cmd.last = 1'b1;
                if (sts.can_issue) begin
                    cmd.issue  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

`ifndef SYNTHESIS
    // The word that closes an item always hands control back for the next one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue && cmd.last |=> state_reg == ST_IDLE)
        else $error("bet_ctrl: last word issued but controller not idle");
`endif

endmodule

`default_nettype wire

/* hdl/bet_datapath.sv */
// Datapath: item register, map and slot stores, counters, read stage and output register.
`timescale 1ns / 1ps
`default_nettype none

module bet_datapath (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire bet_pkg::in_word_t s_data,
    input  wire bet_pkg::bet_cmd_t cmd,
    output bet_pkg::bet_status_t   sts,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output bet_pkg::out_word_t     m_data
);

    bet_pkg::in_word_t item_reg;

    // Needle map store and its per-entry valid flags.
    logic [bet_pkg::MAP_DEPTH-1:0] map_vld_reg;
    logic                          map_hit_vld_reg;
    logic [bet_pkg::MAP_W-1:0]     map_rd_data;
    logic                          map_wr_en;
    logic [bet_pkg::MAP_W-1:0]     map_wr_data;

    // Replacement byte store.
    logic                          rep_wr_en;
    logic [bet_pkg::REP_ADDR_W-1:0] rep_wr_addr;
    logic [bet_pkg::REP_ADDR_W-1:0] rep_rd_addr;
    logic [bet_pkg::BYTE_W-1:0]    rep_rd_data;

    logic [bet_pkg::LEN_W-1:0]     slot_len_reg [bet_pkg::SLOT_COUNT];
    logic [bet_pkg::LEN_W-1:0]     new_len;
    logic                          prefix_sent_reg;
    logic [bet_pkg::TOTAL_W-1:0]   count_reg;

    // Read stage between the stores and the output register.
    logic                          pend_reg;
    logic [1:0]                    pend_kind_reg;
    logic                          pend_last_reg;
    logic [bet_pkg::BYTE_W-1:0]    pend_lit_reg;
    logic [bet_pkg::TOTAL_W-1:0]   pend_total_reg;

    logic                          m_valid_reg;
    bet_pkg::out_word_t            m_data_reg;
    logic                          out_free;
    bet_pkg::out_word_t            pend_word;

    always_comb begin
        map_wr_en   = 1'b0;
        map_wr_data = '0;
        if (cmd.do_cfg && item_reg.operation == bet_pkg::OP_SET_MAP) begin
            if (!item_reg.map_enable) begin
                map_wr_en = 1'b1;
            end else if (32'(item_reg.slot) < bet_pkg::NEEDLE_SLOTS) begin
                map_wr_en   = 1'b1;
                map_wr_data = {1'b1, item_reg.slot[bet_pkg::NEEDLE_W-1:0]};
            end
        end
    end

    assign rep_wr_en = cmd.do_cfg && (item_reg.operation == bet_pkg::OP_WRITE_SLOT)
                       && (32'(item_reg.slot) < bet_pkg::SLOT_COUNT)
                       && (32'(item_reg.position) < bet_pkg::MAX_REPLACEMENT);
    assign rep_wr_addr = bet_pkg::REP_ADDR_W'(32'(item_reg.slot) * bet_pkg::MAX_REPLACEMENT
                         + 32'(item_reg.position));
    assign rep_rd_addr = bet_pkg::REP_ADDR_W'(32'(cmd.slot) * bet_pkg::MAX_REPLACEMENT
                         + 32'(cmd.idx));

    assign new_len = (32'(item_reg.length) > bet_pkg::MAX_REPLACEMENT)
                     ? bet_pkg::LEN_W'(bet_pkg::MAX_REPLACEMENT) : item_reg.length;

    bet_ram #(
        .WIDTH (bet_pkg::MAP_W),
        .DEPTH (bet_pkg::MAP_DEPTH)
    ) u_map_ram (
        .aclk    (aclk),
        .wr_en   (map_wr_en),
        .wr_addr (item_reg.byte_value),
        .wr_data (map_wr_data),
        .rd_en   (cmd.load_item),
        .rd_addr (s_data.byte_value),
        .rd_data (map_rd_data)
    );

    bet_ram #(
        .WIDTH (bet_pkg::BYTE_W),
        .DEPTH (bet_pkg::REP_DEPTH)
    ) u_rep_ram (
        .aclk    (aclk),
        .wr_en   (rep_wr_en),
        .wr_addr (rep_wr_addr),
        .wr_data (item_reg.byte_value),
        .rd_en   (cmd.issue),
        .rd_addr (rep_rd_addr),
        .rd_data (rep_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_vld_reg     <= '0;
            map_hit_vld_reg <= 1'b0;
        end else begin
            if (cmd.load_item) begin
                map_hit_vld_reg <= map_vld_reg[s_data.byte_value];
            end
            if (map_wr_en) begin
                map_vld_reg[item_reg.byte_value] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < bet_pkg::SLOT_COUNT; i++) begin
                slot_len_reg[i] <= '0;
            end
        end else if (cmd.do_cfg && item_reg.operation == bet_pkg::OP_SET_LEN
                     && 32'(item_reg.slot) < bet_pkg::SLOT_COUNT) begin
            slot_len_reg[item_reg.slot] <= new_len;
        end
    end

    // Per-string state: prefix flag and saturating emitted byte count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_sent_reg <= 1'b0;
            count_reg       <= '0;
        end else if (cmd.issue && cmd.kind == bet_pkg::KIND_TERM) begin
            prefix_sent_reg <= 1'b0;
            count_reg       <= '0;
        end else begin
            if (cmd.set_prefix) begin
                prefix_sent_reg <= 1'b1;
            end
            if (cmd.issue && count_reg != '1) begin
                count_reg <= count_reg + bet_pkg::TOTAL_W'(1);
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        pend_word.out_byte     = (pend_kind_reg == bet_pkg::KIND_RAM) ? rep_rd_data
                                 : (pend_kind_reg == bet_pkg::KIND_LIT) ? pend_lit_reg : '0;
        pend_word.terminator   = (pend_kind_reg == bet_pkg::KIND_TERM);
        pend_word.total_length = pend_total_reg;
        pend_word.last         = pend_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.issue) begin
                pend_reg <= 1'b1;
            end else if (out_free) begin
                pend_reg <= 1'b0;
            end
            if (out_free) begin
                m_valid_reg <= pend_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            pend_kind_reg  <= cmd.kind;
            pend_last_reg  <= cmd.last;
            pend_lit_reg   <= item_reg.byte_value;
            pend_total_reg <= (cmd.kind == bet_pkg::KIND_TERM) ? count_reg : '0;
        end
        if (out_free && pend_reg) begin
            m_data_reg <= pend_word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        sts.op          = item_reg.operation;
        sts.prefix_sent = prefix_sent_reg;
        sts.is_needle   = map_hit_vld_reg && map_rd_data[bet_pkg::MAP_W-1];
        sts.needle_slot = map_rd_data[bet_pkg::NEEDLE_W-1:0];
        sts.prefix_len  = slot_len_reg[bet_pkg::PREFIX_SLOT];
        sts.suffix_len  = slot_len_reg[bet_pkg::SUFFIX_SLOT];
        sts.needle_len  = slot_len_reg[bet_pkg::SLOT_W'(map_rd_data[bet_pkg::NEEDLE_W-1:0])];
        sts.can_issue   = !pend_reg || out_free;
    end

`ifndef SYNTHESIS
    // A new read never overwrites a word still held in the read stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> (!pend_reg || out_free))
        else $error("bet_datapath: read stage overrun");

    // A terminator word is the last word of its item and carries no byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.terminator |-> m_data_reg.last && m_data_reg.out_byte == '0)
        else $error("bet_datapath: malformed terminator word");

    // Only a terminator word carries a length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg.terminator |-> m_data_reg.total_length == '0)
        else $error("bet_datapath: length on a data word");

    // The byte count restarts once a terminator has been issued.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue && cmd.kind == bet_pkg::KIND_TERM |=> count_reg == '0 && !prefix_sent_reg)
        else $error("bet_datapath: string state not cleared after terminator");
`endif

endmodule

`default_nettype wire

/* hdl/byte_escape_translator.sv */
// Top level of the byte escape translator: controller and datapath joined.
//
//  Channel | Direction | Handshake          | Word type
//  --------+-----------+--------------------+-------------------
//  s_      | in        | s_valid / s_ready  | bet_pkg::in_word_t
//  m_      | out       | m_valid / m_ready  | bet_pkg::out_word_t
//
// One input word is taken at a time. Accepting it registers the word and reads the
// needle map, and a decode state then acts on the result; a store-loading word or a
// word that emits nothing returns to idle from there. Emitting words leave one per
// cycle after the decode state while the output is not stalled, each byte fetched from
// the single read port of the replacement store.
// Reset is synchronous and active low; it clears the needle map through its valid
// flags, the slot lengths, the prefix flag and the byte count. Replacement bytes
// hold no reset value and need no clearing pass.
// A stalled output holds the word in the output register and one more in the read
// stage; the sequencer simply waits, and input is refused until the word's last
// result has been issued.
`timescale 1ns / 1ps
`default_nettype none

module byte_escape_translator (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire bet_pkg::in_word_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output bet_pkg::out_word_t     m_data
);

    // Commands from the sequencer and status back from the datapath.
    bet_pkg::bet_cmd_t    cmd;
    bet_pkg::bet_status_t sts;

    // The sequencer walks prefix, replacement or pass-through, suffix and terminator phases and
    // decides which word carries the last flag, from lengths the datapath reports.
    bet_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath holds the stores and the two-word output pipeline.
    bet_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
